// ----- hdl/mbpt2_energy_accumulator_assert.svh -----
// assertion macros shared by the energy accumulator rtl
`ifndef MBPT2_ENERGY_ACCUMULATOR_ASSERT_SVH
`define MBPT2_ENERGY_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define MBPT2_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define MBPT2_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/mbpt2_pkg.sv -----
// constants, types and helpers of the mbpt2 energy accumulator
`default_nettype none

package mbpt2_pkg;

   // orbital table
   localparam int NUM_ORBITALS = 256;
   localparam int ORB_W        = $clog2(NUM_ORBITALS);
   localparam int IDX_W        = 8;
   localparam int IDX_EXT_W    = ORB_W + IDX_W;

   // field widths
   localparam int ENERGY_W = 32;
   localparam int VME_W    = 32;
   localparam int DENOM_W  = ENERGY_W + 2;
   localparam int PROD_W   = 2 * VME_W;
   localparam int SUM_W    = 64;

   // divider retires two quotient bits per cycle
   localparam int DIV_ITERS = PROD_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_ITERS);

   // request kinds
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TERM = 1'b1;

   // sequencer states
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_READ = 6'b000010,
      S_PREP = 6'b000100,
      S_DIV  = 6'b001000,
      S_ACC  = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   // orbital index to table address
   function automatic logic [ORB_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
      logic [IDX_EXT_W-1:0] wide;
      wide = IDX_EXT_W'(idx);
      return wide[ORB_W-1:0];
   endfunction

   // index names an existing table entry
   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      return IDX_EXT_W'(idx) < IDX_EXT_W'(NUM_ORBITALS);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/mbpt2_energy_accumulator.sv -----
// second-order perturbation energy accumulator with table, divider and output register
// A load transaction (tuser = 0) writes one Q16.16 orbital energy as it is accepted.
// A term transaction (tuser = 1) reads its four energies through the single table read
// port, forms |v|^2 and the denominator, divides with a shared restoring divider that
// retires two quotient bits per cycle, and adds the signed Q32.32 quotient to a
// saturating sum; no new transaction is taken until the term is done, and a zero
// denominator skips the divide and the add. On tlast the quarter of the sum and the
// zero-denominator and saturation flags go to the output register, and the sum and
// flags clear; a full output register holds the block in its final cycle.
// The energy table has no reset: terms must read only entries loaded since reset.
`default_nettype none

module mbpt2_energy_accumulator (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // orbital_index[7:0], energy_value[39:8], hole_a[47:40], hole_b[55:48],
   // particle_a[63:56], particle_b[71:64], matrix_element[103:72]
   input  wire logic [103:0] req_tdata,
   // func[0]
   input  wire logic [0:0]   req_tuser,
   // last_term
   input  wire logic         req_tlast,
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // corr_energy[63:0]
   output logic [63:0]       rsp_tdata,
   // zero_denominator[0], saturated[1]
   output logic [1:0]        rsp_tuser
);

`include "mbpt2_energy_accumulator_assert.svh"

   // request fields
   logic [mbpt2_pkg::IDX_W-1:0]    f_orb;
   logic [mbpt2_pkg::ENERGY_W-1:0] f_energy;
   logic [mbpt2_pkg::IDX_W-1:0]    f_idx [4];
   logic [mbpt2_pkg::VME_W-1:0]    f_vme;

   assign f_orb    = req_tdata[7:0];
   assign f_energy = req_tdata[39:8];
   assign f_idx[0] = req_tdata[47:40];
   assign f_idx[1] = req_tdata[55:48];
   assign f_idx[2] = req_tdata[63:56];
   assign f_idx[3] = req_tdata[71:64];
   assign f_vme    = req_tdata[103:72];

   // control registers
   mbpt2_pkg::state_type            state_ff, state_in;
   logic [2:0]                      rd_cnt_ff, rd_cnt_in;
   logic [mbpt2_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                            zero_flag_ff, zero_flag_in;
   logic                            sat_flag_ff, sat_flag_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mbpt2_pkg::SUM_W-1:0]     sum_ff, sum_in;

   // datapath registers
   logic [mbpt2_pkg::IDX_W-1:0]          idx_ff [4];
   logic [mbpt2_pkg::IDX_W-1:0]          idx_in [4];
   logic [mbpt2_pkg::VME_W-1:0]          vmag_ff, vmag_in;
   logic                                 last_ff, last_in;
   logic [mbpt2_pkg::PROD_W-1:0]         v2_ff, v2_in;
   logic signed [mbpt2_pkg::DENOM_W-1:0] denom_ff, denom_in;
   logic [mbpt2_pkg::DENOM_W-1:0]        dm_ff, dm_in;
   logic                                 neg_ff, neg_in;
   logic [mbpt2_pkg::DENOM_W-1:0]        rem_ff, rem_in;
   logic [mbpt2_pkg::PROD_W-1:0]         quo_ff, quo_in;
   logic [mbpt2_pkg::SUM_W-1:0]          rsp_data_ff, rsp_data_in;
   logic [1:0]                           rsp_user_ff, rsp_user_in;

   // energy table
   logic [mbpt2_pkg::ENERGY_W-1:0] energy_mem [mbpt2_pkg::NUM_ORBITALS];
   logic [mbpt2_pkg::ENERGY_W-1:0] rdata_ff;
   logic                           rd_ok_ff;
   logic [mbpt2_pkg::ORB_W-1:0]    rd_addr;
   logic                           rd_ok;
   logic                           mem_we;

   // handshakes
   logic req_fire;
   logic out_free;

   assign req_tready = (state_ff == mbpt2_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // table port: load writes, term reads one index per cycle
   assign mem_we  = req_fire && (req_tuser[0] == mbpt2_pkg::FUNC_LOAD)
                    && mbpt2_pkg::in_range(f_orb);
   assign rd_addr = mbpt2_pkg::to_addr(idx_ff[rd_cnt_ff[1:0]]);
   assign rd_ok   = mbpt2_pkg::in_range(idx_ff[rd_cnt_ff[1:0]]);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         energy_mem[mbpt2_pkg::to_addr(f_orb)] <= f_energy;
      end
      rdata_ff <= energy_mem[rd_addr];
      rd_ok_ff <= rd_ok;
   end

   // shared divider step: two restoring subtractions
   logic [mbpt2_pkg::DENOM_W:0]   r1, r2;
   logic                          b1, b2;

   always_comb begin
      r1 = {rem_ff, quo_ff[mbpt2_pkg::PROD_W-1]};
      b1 = (r1 >= {1'b0, dm_ff});
      if (b1) begin
         r1 = r1 - {1'b0, dm_ff};
      end
      r2 = {r1[mbpt2_pkg::DENOM_W-1:0], quo_ff[mbpt2_pkg::PROD_W-2]};
      b2 = (r2 >= {1'b0, dm_ff});
      if (b2) begin
         r2 = r2 - {1'b0, dm_ff};
      end
   end

   // table energy, zero when the index is beyond the table
   logic signed [mbpt2_pkg::DENOM_W-1:0] e_ext;
   assign e_ext = rd_ok_ff ? {{2{rdata_ff[mbpt2_pkg::ENERGY_W-1]}}, rdata_ff}
                           : '0;

   // signed quotient and saturating sum
   logic [mbpt2_pkg::SUM_W-1:0] q_signed;
   logic [mbpt2_pkg::SUM_W:0]   s_wide;
   assign q_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign s_wide   = {sum_ff[mbpt2_pkg::SUM_W-1], sum_ff}
                   + {q_signed[mbpt2_pkg::SUM_W-1], q_signed};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      zero_flag_in = zero_flag_ff;
      sat_flag_in  = sat_flag_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      idx_in       = idx_ff;
      vmag_in      = vmag_ff;
      last_in      = last_ff;
      v2_in        = v2_ff;
      denom_in     = denom_ff;
      dm_in        = dm_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         mbpt2_pkg::S_IDLE: begin
            // capture a term; loads finish in the table write
            if (req_fire && (req_tuser[0] == mbpt2_pkg::FUNC_TERM)) begin
               idx_in    = f_idx;
               vmag_in   = f_vme[mbpt2_pkg::VME_W-1] ? (~f_vme + 1'b1) : f_vme;
               last_in   = req_tlast;
               denom_in  = '0;
               rd_cnt_in = '0;
               state_in  = mbpt2_pkg::S_READ;
            end
         end
         mbpt2_pkg::S_READ: begin
            // square v once, then fold in each energy from the registered table read
            if (rd_cnt_ff == 3'd0) begin
               v2_in = vmag_ff * vmag_ff;
            end else if (rd_cnt_ff <= 3'd2) begin
               denom_in = denom_ff + e_ext;
            end else begin
               denom_in = denom_ff - e_ext;
            end
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == 3'd4) begin
               state_in = mbpt2_pkg::S_PREP;
            end
         end
         mbpt2_pkg::S_PREP: begin
            // zero denominator skips the term
            if (denom_ff == '0) begin
               zero_flag_in = 1'b1;
               state_in     = mbpt2_pkg::S_FIN;
            end else begin
               neg_in     = denom_ff[mbpt2_pkg::DENOM_W-1];
               dm_in      = denom_ff[mbpt2_pkg::DENOM_W-1] ? (~denom_ff + 1'b1)
                                                           : denom_ff;
               rem_in     = '0;
               quo_in     = v2_ff;
               div_cnt_in = '0;
               state_in   = mbpt2_pkg::S_DIV;
            end
         end
         mbpt2_pkg::S_DIV: begin
            rem_in     = r2[mbpt2_pkg::DENOM_W-1:0];
            quo_in     = {quo_ff[mbpt2_pkg::PROD_W-3:0], b1, b2};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == mbpt2_pkg::DIV_CNT_W'(mbpt2_pkg::DIV_ITERS - 1)) begin
               state_in = mbpt2_pkg::S_ACC;
            end
         end
         mbpt2_pkg::S_ACC: begin
            // clamp to the nearest limit on overflow
            if (s_wide[mbpt2_pkg::SUM_W] != s_wide[mbpt2_pkg::SUM_W-1]) begin
               sum_in      = s_wide[mbpt2_pkg::SUM_W]
                           ? {1'b1, {(mbpt2_pkg::SUM_W-1){1'b0}}}
                           : {1'b0, {(mbpt2_pkg::SUM_W-1){1'b1}}};
               sat_flag_in = 1'b1;
            end else begin
               sum_in = s_wide[mbpt2_pkg::SUM_W-1:0];
            end
            state_in = mbpt2_pkg::S_FIN;
         end
         mbpt2_pkg::S_FIN: begin
            // emit quarter of the sum on the last term
            if (!last_ff) begin
               state_in = mbpt2_pkg::S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{2{sum_ff[mbpt2_pkg::SUM_W-1]}},
                               sum_ff[mbpt2_pkg::SUM_W-1:2]};
               rsp_user_in  = {sat_flag_ff, zero_flag_ff};
               sum_in       = '0;
               zero_flag_in = 1'b0;
               sat_flag_in  = 1'b0;
               state_in     = mbpt2_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mbpt2_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbpt2_pkg::S_IDLE;
         rd_cnt_ff    <= '0;
         div_cnt_ff   <= '0;
         zero_flag_ff <= 1'b0;
         sat_flag_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         zero_flag_ff <= zero_flag_in;
         sat_flag_ff  <= sat_flag_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      vmag_ff     <= vmag_in;
      last_ff     <= last_in;
      v2_ff       <= v2_in;
      denom_ff    <= denom_in;
      dm_ff       <= dm_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // checks
   `MBPT2_ASSERT_NOW(a_rem_below_divisor, state_ff == mbpt2_pkg::S_DIV, rem_ff < dm_ff, "divider remainder not below divisor")
   `MBPT2_ASSERT_NOW(a_quotient_bound, state_ff == mbpt2_pkg::S_ACC, quo_ff[mbpt2_pkg::PROD_W-1] == 1'b0, "quotient magnitude above bound")
   `MBPT2_ASSERT_NOW(a_result_from_last, $rose(rsp_valid_ff), $past(state_ff == mbpt2_pkg::S_FIN && last_ff), "result without a last term")
   `MBPT2_ASSERT_NEXT(a_clear_after_emit, state_ff == mbpt2_pkg::S_FIN && last_ff && out_free, sum_ff == '0 && !zero_flag_ff && !sat_flag_ff && rsp_valid_ff, "sum not cleared after result")

endmodule

`default_nettype wire

// ----- test/mbpt2_energy_accumulator_tb.sv -----
// self-checking testbench of the mbpt2 energy accumulator with a scoreboard class
`default_nettype none

module mbpt2_energy_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MIN = -SUM_MAX - 64'sd1;
   localparam int     RANDOM_ITEMS = 1600;

   // one emitted correlation energy with its flags
   typedef struct {
      logic [63:0] corr_energy;
      logic        zero_denominator;
      logic        saturated;
   } energy_result_type;

   // predicts correlation energies and checks them against the block
   class energy_scoreboard;
      logic [31:0]       orbital_energy [mbpt2_pkg::NUM_ORBITALS];
      longint            running_sum;
      bit                zero_seen;
      bit                sat_seen;
      energy_result_type pending_energies[$];
      int                mismatches;
      int                loads_seen;
      int                terms_seen;
      int                results_seen;
      int                zero_results;
      int                sat_results;

      function new();
         running_sum  = 0;
         zero_seen    = 1'b0;
         sat_seen     = 1'b0;
         mismatches   = 0;
         loads_seen   = 0;
         terms_seen   = 0;
         results_seen = 0;
         zero_results = 0;
         sat_results  = 0;
      endfunction

      // accepted request transaction: update the table or fold in one term
      function void note_request(input logic func, input logic [103:0] data,
                                 input logic last);
         longint            denom;
         longint            v;
         longint            q;
         logic [63:0]       vm;
         logic [63:0]       dm;
         logic [63:0]       qm;
         energy_result_type r;
         if (func == mbpt2_pkg::FUNC_LOAD) begin
            loads_seen++;
            orbital_energy[data[7:0]] = data[39:8];
            return;
         end
         terms_seen++;
         denom = longint'($signed(orbital_energy[data[47:40]]))
               + longint'($signed(orbital_energy[data[55:48]]))
               - longint'($signed(orbital_energy[data[63:56]]))
               - longint'($signed(orbital_energy[data[71:64]]));
         v = longint'($signed(data[103:72]));
         if (denom == 0) begin
            zero_seen = 1'b1;
         end else begin
            vm = (v < 0) ? -v : v;
            dm = (denom < 0) ? -denom : denom;
            qm = (vm * vm) / dm;
            q  = (denom < 0) ? -$signed(qm) : $signed(qm);
            // saturating add into the running sum
            if (q > 0 && running_sum > SUM_MAX - q) begin
               running_sum = SUM_MAX;
               sat_seen    = 1'b1;
            end else if (q < 0 && running_sum < SUM_MIN - q) begin
               running_sum = SUM_MIN;
               sat_seen    = 1'b1;
            end else begin
               running_sum = running_sum + q;
            end
         end
         if (last) begin
            r.corr_energy      = running_sum >>> 2;
            r.zero_denominator = zero_seen;
            r.saturated        = sat_seen;
            pending_energies.push_back(r);
            running_sum = 0;
            zero_seen   = 1'b0;
            sat_seen    = 1'b0;
         end
      endfunction

      // accepted result transaction against the oldest prediction
      function void check_result(input logic [63:0] data, input logic [1:0] user);
         energy_result_type r;
         results_seen++;
         if (pending_energies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result energy=%h flags=%b", data, user);
            return;
         end
         r = pending_energies.pop_front();
         if (r.zero_denominator) zero_results++;
         if (r.saturated) sat_results++;
         if (data !== r.corr_energy || user[0] !== r.zero_denominator ||
             user[1] !== r.saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d expected energy=%h zero=%b sat=%b,",
                        results_seen, r.corr_energy, r.zero_denominator, r.saturated,
                        " got energy=%h zero=%b sat=%b", data, user[0], user[1]);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   energy_scoreboard sb;
   int               send_idle;
   int               rsp_idle;
   int               rsp_hold;
   bit               loaded [mbpt2_pkg::NUM_ORBITALS];
   logic [7:0]       loaded_list[$];

   mbpt2_energy_accumulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // result side ready, with random stalls and a counted long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle);
         end
      end
   end

   // observe both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser[0], req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // offer one request transaction and wait until it is taken
   task automatic put_request(input logic func, input logic [103:0] data, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser  <= func;
      req_tdata  <= data;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_load(input logic [7:0] idx, input logic [31:0] value, input logic last);
      if (!loaded[idx]) begin
         loaded[idx] = 1'b1;
         loaded_list.push_back(idx);
      end
      put_request(mbpt2_pkg::FUNC_LOAD, {32'($urandom), 32'($urandom), value, idx}, last);
   endtask

   task automatic send_term(input logic [7:0] ha, input logic [7:0] hb, input logic [7:0] pa,
                            input logic [7:0] pb, input logic [31:0] v, input logic last);
      put_request(mbpt2_pkg::FUNC_TERM, {v, pb, pa, hb, ha, 32'($urandom), 8'($urandom)},
                  last);
   endtask

   // energies: raw random, tiny, moderate, or whole numbers
   function automatic logic [31:0] pick_energy();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $urandom_range(2000) - 1000;
         2:       return $urandom_range(32'h0020_0000) - 32'h0010_0000;
         default: return ($urandom_range(64) - 32) << 16;
      endcase
   endfunction

   function automatic logic [31:0] pick_element();
      case ($urandom_range(5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom_range(4000) - 2000;
         default: return $urandom;
      endcase
   endfunction

   // only orbitals loaded since reset may be named by a term
   function automatic logic [7:0] pick_orbital();
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   task automatic send_random_term(input logic last);
      logic [7:0] ha;
      logic [7:0] hb;
      logic [7:0] pa;
      logic [7:0] pb;
      ha = pick_orbital();
      hb = pick_orbital();
      pa = pick_orbital();
      pb = pick_orbital();
      // mirrored indices give a zero denominator
      case ($urandom_range(11))
         0: begin pa = ha; pb = hb; end
         1: begin pa = hb; pb = ha; end
         default: ;
      endcase
      send_term(ha, hb, pa, pb, pick_element(), last);
   endtask

   task automatic send_random_item();
      if (loaded_list.size() < 4 || $urandom_range(99) < 20)
         send_load(8'($urandom), pick_energy(), 1'($urandom));
      else
         send_random_term($urandom_range(7) == 0);
   endtask

   // stop offering and wait until every expected result has come
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending_energies.size() != 0) @(negedge clock);
   endtask

   // main sequence
   initial begin
      sb          = new();
      send_idle   = 0;
      rsp_idle    = 0;
      rsp_hold    = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = mbpt2_pkg::FUNC_LOAD;
      req_tlast   = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // table entries for the directed terms; tlast on a load is ignored
      send_load(8'd0,   32'h0000_0000, 1'b1);
      send_load(8'd1,   32'h0000_0001, 1'b0);
      send_load(8'd2,   32'hFFFF_FFFF, 1'b0);
      send_load(8'd255, 32'h7FFF_FFFF, 1'b0);
      send_load(8'd254, 32'h8000_0000, 1'b0);
      send_load(8'd3,   32'h0001_0000, 1'b0);
      send_load(8'd4,   32'h0002_8000, 1'b0);
      // largest denominator
      send_term(8'd255, 8'd255, 8'd254, 8'd254, 32'h7FFF_FFFF, 1'b1);
      // smallest positive denominator with the largest square: saturate high
      send_term(8'd1, 8'd0, 8'd0, 8'd0, 32'h8000_0000, 1'b0);
      send_term(8'd1, 8'd0, 8'd0, 8'd0, 32'h8000_0000, 1'b0);
      // zero denominator on the last term, both flags out
      send_term(8'd3, 8'd3, 8'd3, 8'd3, 32'h1234_5678, 1'b1);
      // negative denominator: reach the low limit exactly, then saturate
      send_term(8'd2, 8'd0, 8'd0, 8'd0, 32'h8000_0000, 1'b0);
      send_term(8'd2, 8'd0, 8'd0, 8'd0, 32'h8000_0000, 1'b1);
      send_term(8'd2, 8'd0, 8'd0, 8'd0, 32'h8000_0000, 1'b0);
      send_term(8'd2, 8'd0, 8'd0, 8'd0, 32'h8000_0000, 1'b0);
      send_term(8'd2, 8'd0, 8'd0, 8'd0, 32'h8000_0000, 1'b1);
      // zero element over zero denominator
      send_term(8'd0, 8'd0, 8'd0, 8'd0, 32'h0000_0000, 1'b1);
      // tiny elements, then the largest element, mixed signs
      send_term(8'd3, 8'd4, 8'd1, 8'd2, 32'h0000_0001, 1'b0);
      send_term(8'd4, 8'd3, 8'd255, 8'd0, 32'hFFFF_FFFF, 1'b0);
      send_term(8'd254, 8'd2, 8'd4, 8'd255, 32'h7FFF_FFFF, 1'b1);

      // three idling phases over the random part
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 21 : (phase == 1) ? 64 : 0;
         rsp_idle  = (phase == 0) ? 64 : (phase == 1) ? 21 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            if (phase == 0 && n == 100) begin
               // long receiver hold-off against a burst of last terms
               rsp_hold = 800;
               repeat (12) send_random_term(1'b1);
            end
            if (phase == 1 && n == 200)
               wait_for_results();
            send_random_item();
         end
      end

      wait_for_results();
      repeat (100) @(posedge clock);
      $display("Run covered %0d loads and %0d terms, %0d results checked",
               sb.loads_seen, sb.terms_seen, sb.results_seen);
      $display("Results with zero denominator: %0d, saturated: %0d, mismatches: %0d",
               sb.zero_results, sb.sat_results, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_energies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
